// File: rtl/qts_pkg.sv
`timescale 1ns / 1ps
// Types, character constants and byte classes for the query text sanitizer.
// No dependencies; imported by the top level and the testbench.
package qts_pkg;

  typedef enum logic [3:0] {
    MODE_NORMAL = 4'd0,
    MODE_SPACE  = 4'd1,
    MODE_LINE   = 4'd2,
    MODE_BLOCK  = 4'd3,
    MODE_DQ     = 4'd4,
    MODE_SQ     = 4'd5,
    MODE_NUMBER = 4'd6,
    MODE_SLASH  = 4'd7,
    MODE_MINUS  = 4'd8
  } scan_mode_t;

  // what a byte decided in the normal state leads to
  typedef enum logic [2:0] {
    ACT_DROP,
    ACT_SPACE,
    ACT_ZERO,
    ACT_HOLD_MINUS,
    ACT_HOLD_SLASH,
    ACT_QUOTE,
    ACT_EMIT
  } plain_act_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       end_of_text;
  } result_t;

  localparam logic [7:0]  CH_SPACE  = 8'h20;
  localparam logic [7:0]  CH_LF     = 8'h0A;
  localparam logic [7:0]  CH_DQUOTE = 8'h22;
  localparam logic [7:0]  CH_SQUOTE = 8'h27;
  localparam logic [7:0]  CH_STAR   = 8'h2A;
  localparam logic [7:0]  CH_MINUS  = 8'h2D;
  localparam logic [7:0]  CH_DOT    = 8'h2E;
  localparam logic [7:0]  CH_SLASH  = 8'h2F;
  localparam logic [7:0]  CH_ZERO   = 8'h30;
  localparam logic [7:0]  CH_UNDER  = 8'h5F;
  localparam logic [7:0]  CTRL_MASK = 8'hE0;
  localparam logic [39:0] POLY_TAG  = 40'h706F6C793A;  // "poly:"
  localparam logic [2:0]  COUNT_SAT = 3'd5;

  function automatic logic is_space_b(input logic [7:0] b);
    return (b == CH_SPACE) || (b >= 8'h09 && b <= 8'h0D);
  endfunction

  function automatic logic is_digit_b(input logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  function automatic logic is_word_b(input logic [7:0] b);
    return is_digit_b(b) || (b >= 8'h41 && b <= 8'h5A) ||
           (b >= 8'h61 && b <= 8'h7A) || (b == CH_UNDER);
  endfunction

endpackage

// File: rtl/qts_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces: text input, result output, configuration.
// Depends on nothing but the handshake convention valid && ready.
interface qts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;
  modport source (output valid, in_byte, in_last, input ready);
  modport sink   (input valid, in_byte, in_last, output ready);
endinterface

interface qts_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       has_byte;
  logic       end_of_text;
  modport source (output valid, out_byte, has_byte, end_of_text, input ready);
  modport sink   (input valid, out_byte, has_byte, end_of_text, output ready);
endinterface

interface qts_cfg_if;
  logic valid;
  logic ready;
  logic anonymize;
  modport source (output valid, anonymize, input ready);
  modport sink   (input valid, anonymize, output ready);
endinterface

// File: rtl/query_text_sanitizer_top.sv
`timescale 1ns / 1ps
// Query text sanitizer top level: scanner state, byte decode and result queue.
// Depends on qts_pkg and the channel interfaces in qts_if.sv.

// Takes one text byte per cycle and decides it in the same cycle from the
// scan state; its results (zero, one or two bytes, or a bare end marker on a
// last beat) go into a four-entry result queue whose head drives the output.
// Results leave at one per cycle while output ready is high, and a byte that
// yields two results (a collapsed space or released held byte plus the byte
// itself, or an emptied quote pair) fills two queue entries. Input is taken
// whenever at most two queue entries are occupied, independent of output
// ready. The anonymize register is written through its own channel, which
// is always ready; write it only while the block is idle.
module query_text_sanitizer_top
  import qts_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  qts_in_if.sink    in_ch,
  qts_out_if.source out_ch,
  qts_cfg_if.sink   cfg
);

  localparam int QDEPTH = 4;

  // registers
  logic                anonymize;
  scan_mode_t          mode;
  logic [39:0]         recent;
  logic [2:0]          out_count;
  logic                star;
  result_t             q [QDEPTH];
  logic [2:0]          q_cnt;

  // next values and decode
  scan_mode_t          mode_next;
  logic                star_next;
  logic [39:0]         recent_next;
  logic [2:0]          out_count_next;
  result_t             q_next [QDEPTH];
  logic [2:0]          q_cnt_next;

  logic [7:0]          b;
  logic                last;
  logic                accept;
  logic                pop;
  logic                pre_v;
  logic [7:0]          pre_b;
  logic                do_plain;
  logic [39:0]         r1;
  logic [2:0]          c1;
  plain_act_t          act;
  logic [1:0]          p_n;
  logic [7:0]          p_b;
  logic [1:0]          n_new;
  result_t             item0;
  result_t             item1;
  logic [1:0]          n_items;
  logic [2:0]          base;
  logic [3:0]          cnt_sum;

  assign b      = in_ch.in_byte;
  assign last   = in_ch.in_last;
  assign in_ch.ready = (q_cnt <= 3'd2);
  assign accept = in_ch.valid && in_ch.ready;
  assign pop    = (q_cnt != 3'd0) && out_ch.ready;
  assign cfg.ready = 1'b1;

  // prefix byte from the current state, and whether the byte goes through
  // the normal-state decision afterwards
  always_comb begin
    pre_v    = 1'b0;
    pre_b    = CH_SPACE;
    do_plain = 1'b0;
    unique case (mode)
      MODE_SPACE: begin
        if (!is_space_b(b)) begin
          pre_v    = (out_count != 3'd0) && is_word_b(recent[7:0]) &&
                     (is_word_b(b) || b == CH_MINUS);
          pre_b    = CH_SPACE;
          do_plain = 1'b1;
        end
      end
      MODE_NUMBER: do_plain = !(is_digit_b(b) || b == CH_DOT);
      MODE_SLASH: begin
        if (b != CH_SLASH && b != CH_STAR) begin
          pre_v    = 1'b1;
          pre_b    = CH_SLASH;
          do_plain = 1'b1;
        end
      end
      MODE_MINUS: begin
        pre_v    = 1'b1;
        pre_b    = is_digit_b(b) ? CH_ZERO : CH_MINUS;
        do_plain = !is_digit_b(b);
      end
      MODE_LINE, MODE_BLOCK, MODE_DQ, MODE_SQ: ;
      MODE_NORMAL: do_plain = 1'b1;
      default: do_plain = 1'b1;
    endcase
  end

  always_comb begin
    r1 = pre_v ? {recent[31:0], pre_b} : recent;
    c1 = (pre_v && out_count != COUNT_SAT) ? out_count + 3'd1 : out_count;
  end

  always_comb begin
    priority if (!do_plain) begin
      act = ACT_DROP;
    end else if (is_space_b(b)) begin
      act = ACT_SPACE;
    end else if (anonymize && is_digit_b(b)) begin
      act = ACT_ZERO;
    end else if (anonymize && b == CH_MINUS) begin
      act = last ? ACT_EMIT : ACT_HOLD_MINUS;
    end else if (anonymize && (b == CH_DQUOTE || b == CH_SQUOTE) &&
                 c1 >= COUNT_SAT && r1 == POLY_TAG) begin
      act = ACT_QUOTE;
    end else if (b == CH_SLASH) begin
      act = last ? ACT_EMIT : ACT_HOLD_SLASH;
    end else if ((b & CTRL_MASK) != 8'h00) begin
      act = ACT_EMIT;
    end else begin
      act = ACT_DROP;
    end
  end

  // next state
  always_comb begin
    mode_next = mode;
    star_next = star;
    unique case (mode)
      MODE_LINE:  if (b == CH_LF) mode_next = MODE_SPACE;
      MODE_BLOCK: begin
        if (b == CH_SLASH && star) mode_next = MODE_NORMAL;
        else star_next = (b == CH_STAR);
      end
      MODE_DQ:    if (b == CH_DQUOTE) mode_next = MODE_NORMAL;
      MODE_SQ:    if (b == CH_SQUOTE) mode_next = MODE_NORMAL;
      MODE_SLASH: begin
        if (b == CH_SLASH) begin
          mode_next = MODE_LINE;
        end else if (b == CH_STAR) begin
          mode_next = MODE_BLOCK;
          star_next = 1'b1;  // the opener's star closes "/*/"
        end
      end
      MODE_MINUS: if (is_digit_b(b)) mode_next = MODE_NUMBER;
      MODE_NORMAL, MODE_SPACE, MODE_NUMBER: ;
      default: ;
    endcase
    if (do_plain) begin
      unique case (act)
        ACT_SPACE:      mode_next = MODE_SPACE;
        ACT_ZERO:       mode_next = MODE_NUMBER;
        ACT_HOLD_MINUS: mode_next = MODE_MINUS;
        ACT_HOLD_SLASH: mode_next = MODE_SLASH;
        ACT_QUOTE:      mode_next = (b == CH_DQUOTE) ? MODE_DQ : MODE_SQ;
        ACT_EMIT, ACT_DROP: mode_next = MODE_NORMAL;
        default:        mode_next = MODE_NORMAL;
      endcase
    end
  end

  // outputs of the step
  always_comb begin
    unique case (act)
      ACT_ZERO:  begin p_n = 2'd1; p_b = CH_ZERO; end
      ACT_QUOTE: begin p_n = 2'd2; p_b = b;       end
      ACT_EMIT:  begin p_n = 2'd1; p_b = b;       end
      ACT_DROP, ACT_SPACE, ACT_HOLD_MINUS, ACT_HOLD_SLASH: begin
        p_n = 2'd0;
        p_b = b;
      end
      default:   begin p_n = 2'd0; p_b = b;       end
    endcase

    n_new = p_n + {1'b0, pre_v};
    unique case (p_n)
      2'd1:    recent_next = {r1[31:0], p_b};
      2'd2:    recent_next = {r1[23:0], p_b, p_b};
      default: recent_next = r1;
    endcase
    cnt_sum        = {1'b0, c1} + {2'b00, p_n};
    out_count_next = (cnt_sum > {1'b0, COUNT_SAT}) ? COUNT_SAT : cnt_sum[2:0];

    item0.out_byte    = pre_v ? pre_b : p_b;
    item0.has_byte    = 1'b1;
    item0.end_of_text = last && (n_new == 2'd1);
    item1.out_byte    = p_b;
    item1.has_byte    = 1'b1;
    item1.end_of_text = last;
    n_items           = n_new;
    if (n_new == 2'd0 && last) begin
      // bare end marker
      item0.out_byte    = 8'h00;
      item0.has_byte    = 1'b0;
      item0.end_of_text = 1'b1;
      n_items           = 2'd1;
    end
  end

  // result queue: head at entry 0, new results appended behind the survivors
  always_comb begin
    base = q_cnt - {2'b00, pop};
    for (int i = 0; i < QDEPTH; i++) begin
      q_next[i] = (pop && i < QDEPTH - 1) ? q[(i + 1) % QDEPTH] : q[i];
    end
    if (accept) begin
      for (int i = 0; i < QDEPTH; i++) begin
        if (n_items != 2'd0 && i == int'(base)) q_next[i] = item0;
        if (n_items == 2'd2 && i == int'(base) + 1) q_next[i] = item1;
      end
    end
    q_cnt_next = base + (accept ? {1'b0, n_items} : 3'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      anonymize <= 1'b0;
      mode      <= MODE_NORMAL;
      recent    <= '0;
      out_count <= '0;
      star      <= 1'b0;
      q_cnt     <= '0;
    end else begin
      if (cfg.valid) anonymize <= cfg.anonymize;
      if (accept) begin
        if (last) begin
          mode      <= MODE_NORMAL;
          recent    <= '0;
          out_count <= '0;
          star      <= 1'b0;
        end else begin
          mode      <= mode_next;
          recent    <= recent_next;
          out_count <= out_count_next;
          star      <= star_next;
        end
      end
      q_cnt <= q_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QDEPTH; i++) q[i] <= q_next[i];
  end

  assign out_ch.valid       = (q_cnt != 3'd0);
  assign out_ch.out_byte    = q[0].out_byte;
  assign out_ch.has_byte    = q[0].has_byte;
  assign out_ch.end_of_text = q[0].end_of_text;

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_cnt <= 3'(QDEPTH))
    else $error("result queue overfilled");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    accept && last |=> mode == MODE_NORMAL && out_count == 3'd0 && !star)
    else $error("scan state not cleared after end of text");

  a_marker_form: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.has_byte |-> out_ch.end_of_text && out_ch.out_byte == 8'h00)
    else $error("bare result is not an end marker");

  a_count_sat: assert property (@(posedge clk) disable iff (rst)
    out_count <= COUNT_SAT)
    else $error("output count past saturation");

  a_pop_moves: assert property (@(posedge clk) disable iff (rst)
    pop && !accept |=> q_cnt == $past(q_cnt) - 3'd1)
    else $error("queue count wrong after a beat leaves");

endmodule

// File: tb/query_text_sanitizer_top_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for query_text_sanitizer_top: directed table, then random texts.
// Depends on qts_pkg and the channel interfaces in qts_if.sv.
module query_text_sanitizer_top_tb;
  import qts_pkg::*;

  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 60;
  localparam int PHASE_BYTES   = 40;

  typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;

  typedef enum int {
    TOK_WORD, TOK_NUM, TOK_WS, TOK_LINE_CMT, TOK_BLOCK_CMT, TOK_POLY, TOK_PUNCT, TOK_NOISE
  } tok_t;

  typedef struct packed {
    row_kind_t  kind;
    logic [7:0] b;
    logic       l;
    logic       chk;
    result_t    exp;
  } row_t;

  localparam result_t BARE_END = '{out_byte: 8'h00, has_byte: 1'b0, end_of_text: 1'b1};

  logic clk;
  logic rst;

  qts_in_if  in_ch();
  qts_out_if out_ch();
  qts_cfg_if cfg_ch();

  query_text_sanitizer_top DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg_ch)
  );

  // predictor state
  logic         p_anon;
  scan_mode_t   p_mode;
  logic [39:0]  p_recent;
  logic [2:0]   p_count;
  logic         p_star;

  result_t step_res[$];
  result_t clean_q[$];
  row_t    offer_q[$];
  row_t    dir_tab[$];
  logic [7:0] text_buf[$];

  int  errors;
  int  n_sent;
  int  n_in;
  int  n_out;
  int  n_texts;
  int  tx_idle_pct;
  int  rx_idle_pct;
  bit  hold_armed;
  bit  hold_done;

  string word_chars  = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_";
  string digit_chars = "0123456789";
  string punct_chars = "-/*.;()=\"'[],:";
  string fill_chars  = "*/a x";

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("FAIL query_text_sanitizer_top");
    $finish;
  end

  function automatic logic is_blank(input logic [7:0] b);
    return b inside {CH_SPACE, [8'h09:8'h0D]};
  endfunction

  function automatic logic is_num_char(input logic [7:0] b);
    return b inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_word_char(input logic [7:0] b);
    return is_num_char(b) || (b inside {[8'h41:8'h5A], [8'h61:8'h7A], CH_UNDER});
  endfunction

  function automatic void restart_text();
    p_mode   = MODE_NORMAL;
    p_recent = '0;
    p_count  = '0;
    p_star   = 1'b0;
  endfunction

  function automatic void put_char(input logic [7:0] c);
    step_res.push_back(result_t'{out_byte: c, has_byte: 1'b1, end_of_text: 1'b0});
    p_recent = {p_recent[31:0], c};
    if (p_count < COUNT_SAT) p_count++;
  endfunction

  // a byte seen from the normal state
  function automatic void decide_plain(input logic [7:0] b, input logic l);
    p_mode = MODE_NORMAL;
    if (is_blank(b)) begin
      p_mode = MODE_SPACE;
    end else if (p_anon && is_num_char(b)) begin
      put_char(CH_ZERO);
      p_mode = MODE_NUMBER;
    end else if (p_anon && b == CH_MINUS) begin
      if (l) put_char(b);
      else p_mode = MODE_MINUS;
    end else if (p_anon && (b == CH_DQUOTE || b == CH_SQUOTE) && p_count >= COUNT_SAT &&
                 p_recent == POLY_TAG) begin
      put_char(b);
      put_char(b);
      p_mode = (b == CH_DQUOTE) ? MODE_DQ : MODE_SQ;
    end else if (b == CH_SLASH) begin
      if (l) put_char(b);
      else p_mode = MODE_SLASH;
    end else if ((b & CTRL_MASK) != 8'h00) begin
      put_char(b);
    end
  endfunction

  // results caused by one input beat, left in step_res
  function automatic void sanitize_step(input logic [7:0] b, input logic l);
    step_res.delete();
    case (p_mode)
      MODE_SPACE: begin
        if (!is_blank(b)) begin
          if (p_count != 0 && is_word_char(p_recent[7:0]) &&
              (is_word_char(b) || b == CH_MINUS))
            put_char(CH_SPACE);
          decide_plain(b, l);
        end
      end
      MODE_LINE: begin
        if (b == CH_LF) p_mode = MODE_SPACE;
      end
      MODE_BLOCK: begin
        if (b == CH_SLASH && p_star) p_mode = MODE_NORMAL;
        else p_star = (b == CH_STAR);
      end
      MODE_DQ: begin
        if (b == CH_DQUOTE) p_mode = MODE_NORMAL;
      end
      MODE_SQ: begin
        if (b == CH_SQUOTE) p_mode = MODE_NORMAL;
      end
      MODE_NUMBER: begin
        if (!(is_num_char(b) || b == CH_DOT)) decide_plain(b, l);
      end
      MODE_SLASH: begin
        if (b == CH_SLASH) begin
          p_mode = MODE_LINE;
        end else if (b == CH_STAR) begin
          p_mode = MODE_BLOCK;
          p_star = 1'b1;
        end else begin
          put_char(CH_SLASH);
          decide_plain(b, l);
        end
      end
      MODE_MINUS: begin
        if (is_num_char(b)) begin
          put_char(CH_ZERO);
          p_mode = MODE_NUMBER;
        end else begin
          put_char(CH_MINUS);
          decide_plain(b, l);
        end
      end
      default: begin
        decide_plain(b, l);
      end
    endcase
    if (l) begin
      if (step_res.size() == 0) step_res.push_back(BARE_END);
      else step_res[step_res.size() - 1].end_of_text = 1'b1;
      restart_text();
    end
  endfunction

  // predictor and scoreboard share one edge so input and output beats never race
  always @(posedge clk) begin
    result_t want;
    row_t    src;
    if (rst) begin
      p_anon = 1'b0;
      restart_text();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) p_anon = cfg_ch.anonymize;
      if (in_ch.valid && in_ch.ready) begin
        src = offer_q.pop_front();
        sanitize_step(in_ch.in_byte, in_ch.in_last);
        if (src.chk) clean_q.push_back(src.exp);
        else foreach (step_res[i]) clean_q.push_back(step_res[i]);
        n_in++;
      end
      if (out_ch.valid && out_ch.ready) begin
        n_out++;
        if (clean_q.size() == 0) begin
          if (errors < 10)
            $display("%0t: unexpected beat byte %h has_byte %b end %b", $time,
                     out_ch.out_byte, out_ch.has_byte, out_ch.end_of_text);
          errors++;
        end else begin
          want = clean_q.pop_front();
          if (out_ch.out_byte !== want.out_byte || out_ch.has_byte !== want.has_byte ||
              out_ch.end_of_text !== want.end_of_text) begin
            if (errors < 10)
              $display("%0t: mismatch exp byte %h has %b end %b, got byte %h has %b end %b",
                       $time, want.out_byte, want.has_byte, want.end_of_text,
                       out_ch.out_byte, out_ch.has_byte, out_ch.end_of_text);
            errors++;
          end
        end
      end
    end
  end

  // receiver: random ready, plus one long hold-off once armed
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_armed && !hold_done) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      out_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  function automatic void add_row(input logic [7:0] b, input logic l);
    row_t r;
    r = '0;
    r.kind = ROW_BYTE;
    r.b = b;
    r.l = l;
    dir_tab.push_back(r);
  endfunction

  function automatic void add_checked(input logic [7:0] b, input logic l, input result_t e);
    row_t r;
    r = '0;
    r.kind = ROW_BYTE;
    r.b = b;
    r.l = l;
    r.chk = 1'b1;
    r.exp = e;
    dir_tab.push_back(r);
  endfunction

  function automatic void add_cfg(input logic v);
    row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.b = {7'd0, v};
    dir_tab.push_back(r);
  endfunction

  function automatic logic [7:0] pick(input string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  function automatic void add_token();
    tok_t       tk;
    logic [7:0] q;
    tk = tok_t'($urandom_range(0, TOK_NOISE));
    case (tk)
      TOK_WORD: begin
        repeat ($urandom_range(1, 4)) text_buf.push_back(pick(word_chars));
      end
      TOK_NUM: begin
        if ($urandom_range(0, 2) == 0) text_buf.push_back(CH_MINUS);
        repeat ($urandom_range(1, 3)) text_buf.push_back(pick(digit_chars));
        if ($urandom_range(0, 2) == 0) begin
          text_buf.push_back(CH_DOT);
          text_buf.push_back(pick(digit_chars));
        end
      end
      TOK_WS: begin
        repeat ($urandom_range(1, 3))
          text_buf.push_back(($urandom_range(0, 5) == 5) ? CH_SPACE :
                             8'h09 + 8'($urandom_range(0, 4)));
      end
      TOK_LINE_CMT: begin
        text_buf.push_back(CH_SLASH);
        text_buf.push_back(CH_SLASH);
        repeat ($urandom_range(0, 3)) text_buf.push_back(pick(punct_chars));
        text_buf.push_back(CH_LF);
      end
      TOK_BLOCK_CMT: begin
        text_buf.push_back(CH_SLASH);
        text_buf.push_back(CH_STAR);
        repeat ($urandom_range(0, 3)) text_buf.push_back(pick(fill_chars));
        text_buf.push_back(CH_STAR);
        text_buf.push_back(CH_SLASH);
      end
      TOK_POLY: begin
        for (int i = 4; i >= 0; i--) text_buf.push_back(POLY_TAG[i*8 +: 8]);
        q = ($urandom_range(0, 1) == 1) ? CH_DQUOTE : CH_SQUOTE;
        text_buf.push_back(q);
        repeat ($urandom_range(0, 3)) text_buf.push_back(pick(word_chars));
        text_buf.push_back(q);
      end
      TOK_PUNCT: begin
        text_buf.push_back(pick(punct_chars));
      end
      default: begin
        text_buf.push_back(8'($urandom_range(0, 255)));
      end
    endcase
  endfunction

  task automatic offer_byte(input row_t r);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    offer_q.push_back(r);
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= r.b;
    in_ch.in_last <= r.l;
    n_sent++;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (clean_q.size() != 0) @(posedge clk);
    // a held byte may still be in flight with nothing expected
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_anon(input logic v);
    wait_idle();
    cfg_ch.valid     <= 1'b1;
    cfg_ch.anonymize <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send_text();
    row_t r;
    text_buf.delete();
    repeat ($urandom_range(1, 6)) add_token();
    // some texts are cut short, leaving comments and quotes open
    if ($urandom_range(0, 4) == 0)
      text_buf = text_buf[0:$urandom_range(0, text_buf.size() - 1)];
    foreach (text_buf[i]) begin
      r = '0;
      r.kind = ROW_BYTE;
      r.b = text_buf[i];
      r.l = (i == text_buf.size() - 1);
      offer_byte(r);
    end
    n_texts++;
  endtask

  task automatic random_phase();
    int stop_at;
    stop_at = n_sent + PHASE_BYTES;
    while (n_sent < stop_at) send_text();
  endtask

  initial begin
    in_ch.valid      = 1'b0;
    in_ch.in_byte    = 8'h00;
    in_ch.in_last    = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.anonymize = 1'b0;
    rst              = 1'b1;
    tx_idle_pct      = 33;
    rx_idle_pct      = 65;

    // anonymize off: extremes, whitespace collapse, comments, held slash
    add_checked(8'hFF, 1'b1, result_t'{8'hFF, 1'b1, 1'b1});
    add_checked("a", 1'b0, result_t'{"a", 1'b1, 1'b0});
    add_row(" ", 1'b0);
    add_row(8'h0B, 1'b0);
    add_row("b", 1'b0);
    add_row("/", 1'b0);
    add_row("/", 1'b0);
    add_row("x", 1'b0);
    add_row("\n", 1'b0);
    add_row("-", 1'b0);
    add_row("/", 1'b0);
    add_row("*", 1'b0);
    add_row("/", 1'b0);
    add_row("/", 1'b0);
    add_row("*", 1'b0);
    add_checked(8'h00, 1'b1, BARE_END);
    add_checked("/", 1'b1, result_t'{"/", 1'b1, 1'b1});
    // anonymize on: numbers, poly quote, trailing blank, held minus across a write
    add_cfg(1'b1);
    add_row("-", 1'b0);
    add_row("9", 1'b0);
    add_row(".", 1'b0);
    add_row("p", 1'b0);
    add_row("o", 1'b0);
    add_row("l", 1'b0);
    add_row("y", 1'b0);
    add_row(":", 1'b0);
    add_row("\"", 1'b0);
    add_row("q", 1'b0);
    add_row("\"", 1'b0);
    add_checked(" ", 1'b1, BARE_END);
    add_row("-", 1'b0);
    add_cfg(1'b0);
    add_row("3", 1'b1);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) write_anon(dir_tab[i].b[0]);
      else offer_byte(dir_tab[i]);
    end

    write_anon(1'b1);
    random_phase();

    tx_idle_pct = 65;
    rx_idle_pct = 33;
    write_anon(1'b0);
    random_phase();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_anon(1'b1);
    hold_armed = 1'b1;
    random_phase();

    wait_idle();
    $display("%0d text bytes in %0d texts, %0d result beats, anonymize on and off",
             n_in, n_texts + 5, n_out);
    $display("one %0d-cycle output hold-off under full input load, %0d mismatches",
             HOLD_CYCLES, errors);
    if (errors == 0) begin
      $display("PASS query_text_sanitizer_top");
    end else begin
      $display("FAIL query_text_sanitizer_top");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/qts_pkg.sv
rtl/qts_if.sv
rtl/query_text_sanitizer_top.sv
tb/query_text_sanitizer_top_tb.sv
